// ===== src/dfs_adjacency_matrix_order_macros.svh =====
// Assertion macros used by the checker of the traversal block
`ifndef DFS_ADJACENCY_MATRIX_ORDER_MACROS_SVH
`define DFS_ADJACENCY_MATRIX_ORDER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dfs_pkg.sv =====
package dfs_pkg;

    localparam int DFS_MAX_VERTICES_DEF = 32;
    localparam int VERT_W               = 5;
    localparam int POS_W                = 5;
    localparam int CFG_W                = 6;
    localparam int CNT_W                = 6;
    localparam int RES_CAP              = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

endpackage

// ===== src/dfs_adjacency_matrix_order.sv =====
// Depth-first visit order of an undirected graph. Edge transactions load a symmetric
// adjacency matrix held in a row memory with one write and one read port; a transaction
// with i_last_edge set starts a walk from vertex 0 that takes neighbours in ascending
// order and returns one result per reached vertex, the final one flagged by o_last_visit,
// at most 32 results. Matrix and visit marks are cleared when the walk ends. A transaction
// without a usable edge leaves the matrix as it is; a loaded edge does a read-modify-write
// of both rows through the row memory. A walk reads the row of the current vertex and
// searches its lowest unvisited bit in the shared scan step, and reads the stack memory
// on each backtrack; output stall holds it. The input channel stalls while an edge is
// loaded or a walk runs, until the final result is registered.
module dfs_adjacency_matrix_order
    import dfs_pkg::*;
#(
    parameter int MAX_VERTICES = DFS_MAX_VERTICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [VERT_W-1:0] i_vert_a,
    input  logic [VERT_W-1:0] i_vert_b,
    input  logic              i_edge_valid,
    input  logic              i_last_edge,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VERT_W-1:0] o_visit_vertex,
    output logic [POS_W-1:0]  o_visit_position,
    output logic              o_last_visit
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NW > CFG_W) ? NW : CFG_W;
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WRA   = 8'b0000_0010,
        S_WRB   = 8'b0000_0100,
        S_START = 8'b0000_1000,
        S_ROW   = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_POP   = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } t_state;

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_cfg;
    logic [VW-1:0]           r_a, n_a;
    logic [VW-1:0]           r_b, n_b;
    logic                    r_last, n_last;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [NW-1:0]           r_depth, n_depth;
    logic [VW-1:0]           r_top, n_top;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [VW-1:0]           r_pend_vertex, n_pend_vertex;
    logic [POS_W-1:0]        r_pend_pos, n_pend_pos;
    logic                    r_ov;
    logic [VERT_W-1:0]       r_ovtx;
    logic [POS_W-1:0]        r_opos;
    logic                    r_olast;

    logic [MAX_VERTICES-1:0] mem_adj [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_adj_rd;
    logic                    r_adj_rd_vld;
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [VW-1:0]           mem_stk [MAX_VERTICES];
    logic [VW-1:0]           r_stk_rd;

    logic                    adj_re, adj_we, stk_re, stk_we, row_clr;
    logic [VW-1:0]           adj_ra, adj_wa, stk_ra, stk_wa, stk_wd;
    logic [MAX_VERTICES-1:0] adj_wd;
    logic                    out_ld, out_last;

    logic [CW-1:0]           w_cfg_ext, w_n, w_a_ext, w_b_ext;
    logic [MAX_VERTICES-1:0] w_nmask, w_row, w_cand, w_iso;
    logic [VW-1:0]           w_idx;
    logic                    w_found, w_room, w_edge_ok, w_out_free;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic [NW-1:0]           w_depth_m2;

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_visit_vertex   = r_ovtx;
    assign o_visit_position = r_opos;
    assign o_last_visit     = r_olast;

    assign w_cfg_ext  = CW'(r_cfg);
    assign w_a_ext    = CW'(i_vert_a);
    assign w_b_ext    = CW'(i_vert_b);
    assign w_edge_ok  = i_edge_valid && (w_a_ext < w_n) && (w_b_ext < w_n);
    assign w_row      = r_adj_rd_vld ? r_adj_rd : '0;
    assign w_cand     = w_row & ~r_visited & w_nmask;
    assign w_found    = |w_cand;
    assign w_iso      = w_cand & (~w_cand + ROW_ONE);
    assign w_room     = (r_depth < NW'(MAX_VERTICES));
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_cnt_inc  = r_count + CNT_W'(1);
    assign w_depth_m2 = r_depth - NW'(2);

    always_comb begin
        if (r_cfg == '0) begin
            w_n = CW'(1);
        end else if (w_cfg_ext > CW'(MAX_VERTICES)) begin
            w_n = CW'(MAX_VERTICES);
        end else begin
            w_n = w_cfg_ext;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_nmask[i] = (CW'(i) < w_n);
        end
    end

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (w_iso[i]) begin
                w_idx = w_idx | VW'(i);
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_a           = r_a;
        n_b           = r_b;
        n_last        = r_last;
        n_visited     = r_visited;
        n_depth       = r_depth;
        n_top         = r_top;
        n_count       = r_count;
        n_pend_vertex = r_pend_vertex;
        n_pend_pos    = r_pend_pos;
        adj_re        = 1'b0;
        adj_ra        = r_top;
        adj_we        = 1'b0;
        adj_wa        = r_a;
        adj_wd        = '0;
        stk_we        = 1'b0;
        stk_wa        = r_depth[VW-1:0];
        stk_wd        = w_idx;
        stk_re        = 1'b0;
        stk_ra        = w_depth_m2[VW-1:0];
        row_clr       = 1'b0;
        out_ld        = 1'b0;
        out_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a    = w_a_ext[VW-1:0];
                    n_b    = w_b_ext[VW-1:0];
                    n_last = i_last_edge;
                    if (w_edge_ok) begin
                        adj_re  = 1'b1;
                        adj_ra  = w_a_ext[VW-1:0];
                        n_state = S_WRA;
                    end else if (i_last_edge) begin
                        n_state = S_START;
                    end
                end
            end
            S_WRA: begin
                adj_we  = 1'b1;
                adj_wa  = r_a;
                adj_wd  = w_row | (ROW_ONE << r_b);
                adj_re  = 1'b1;
                adj_ra  = r_b;
                n_state = S_WRB;
            end
            S_WRB: begin
                adj_we  = 1'b1;
                adj_wa  = r_b;
                adj_wd  = w_row | (ROW_ONE << r_a);
                n_state = r_last ? S_START : S_IDLE;
            end
            S_START: begin
                n_visited     = ROW_ONE;
                stk_we        = 1'b1;
                stk_wa        = '0;
                stk_wd        = '0;
                n_depth       = NW'(1);
                n_top         = '0;
                n_pend_vertex = '0;
                n_pend_pos    = '0;
                n_count       = CNT_W'(1);
                adj_re        = 1'b1;
                adj_ra        = '0;
                n_state       = S_SCAN;
            end
            S_ROW: begin
                adj_re  = 1'b1;
                adj_ra  = r_top;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_found && w_room) begin
                    if (w_out_free) begin
                        out_ld        = 1'b1;
                        n_pend_vertex = w_idx;
                        n_pend_pos    = r_count[POS_W-1:0];
                        n_count       = w_cnt_inc;
                        n_visited     = r_visited | (ROW_ONE << w_idx);
                        stk_we        = 1'b1;
                        n_depth       = r_depth + NW'(1);
                        n_top         = w_idx;
                        n_state       = (w_cnt_inc == CNT_W'(RES_CAP)) ? S_FLUSH : S_ROW;
                    end
                end else if (r_depth == NW'(1)) begin
                    n_state = S_FLUSH;
                end else begin
                    stk_re  = 1'b1;
                    n_depth = r_depth - NW'(1);
                    n_state = S_POP;
                end
            end
            S_POP: begin
                adj_re  = 1'b1;
                adj_ra  = r_stk_rd;
                n_top   = r_stk_rd;
                n_state = S_SCAN;
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    out_ld    = 1'b1;
                    out_last  = 1'b1;
                    n_visited = '0;
                    n_depth   = '0;
                    n_count   = '0;
                    row_clr   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_RESET;
            r_last    <= 1'b0;
            r_visited <= '0;
            r_depth   <= '0;
            r_count   <= '0;
            r_ov      <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_visited <= n_visited;
            r_depth   <= n_depth;
            r_count   <= n_count;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (out_ld) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (row_clr) begin
                r_row_vld <= '0;
            end else if (adj_we) begin
                r_row_vld[adj_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a           <= n_a;
        r_b           <= n_b;
        r_top         <= n_top;
        r_pend_vertex <= n_pend_vertex;
        r_pend_pos    <= n_pend_pos;
        if (out_ld) begin
            r_ovtx  <= VERT_W'(r_pend_vertex);
            r_opos  <= r_pend_pos;
            r_olast <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            mem_adj[adj_wa] <= adj_wd;
        end
        if (adj_re) begin
            r_adj_rd     <= mem_adj[adj_ra];
            r_adj_rd_vld <= r_row_vld[adj_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= mem_stk[stk_ra];
        end
    end

endmodule

// ===== src/dfs_chk.sv =====
`include "dfs_adjacency_matrix_order_macros.svh"

module dfs_chk
    import dfs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [VERT_W-1:0] o_visit_vertex,
    input logic [POS_W-1:0]  o_visit_position,
    input logic              o_last_visit
);

    `DFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_visit_vertex) && $stable(o_visit_position)
        && $stable(o_last_visit), "stalled result transaction changed")

    `DFS_ASSERT_NOW(a_first_is_root, i_clk, i_rst_n,
        o_out_valid && (o_visit_position == POS_W'(0)),
        o_visit_vertex == VERT_W'(0), "first visit is not vertex zero")

    `DFS_ASSERT_NOW(a_busy_mid_walk, i_clk, i_rst_n, o_out_valid && !o_last_visit,
        o_in_stall, "input taken while a walk is still running")

    `DFS_ASSERT_NEXT(a_pos_step, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_last_visit,
        !o_out_valid || (o_visit_position == $past(o_visit_position) + POS_W'(1)),
        "visit position did not advance by one")

endmodule

bind dfs_adjacency_matrix_order dfs_chk u_dfs_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_visit_vertex   (o_visit_vertex),
    .o_visit_position (o_visit_position),
    .o_last_visit     (o_last_visit)
);
